### sv/mp2d_pkg.sv
// ----------------------------------------------------------------------------
// mp2d_pkg
// Shared types, defaults and register codes of the 2-D max pooling block.
// ----------------------------------------------------------------------------
package mp2d_pkg;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;
   localparam int DEF_MAX_KERNEL = 8;
   localparam int DEF_DATA_BITS  = 16;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 11;
   localparam int CFG_DIM_BITS   = 11;
   localparam int CFG_K_BITS     = 4;
   localparam int OUT_IDX_BITS   = 10;

   localparam logic [CFG_DIM_BITS-1:0] RST_IN_HEIGHT = 11'd1024;
   localparam logic [CFG_DIM_BITS-1:0] RST_IN_WIDTH  = 11'd1024;
   localparam logic [CFG_K_BITS-1:0]   RST_KERNEL    = 4'd2;
   localparam logic [CFG_K_BITS-1:0]   RST_STRIDE    = 4'd2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_IN_HEIGHT = 3'd0,
      CSR_IN_WIDTH  = 3'd1,
      CSR_KERNEL_H  = 3'd2,
      CSR_KERNEL_W  = 3'd3,
      CSR_STRIDE_H  = 3'd4,
      CSR_STRIDE_W  = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROW,
      ST_COL,
      ST_WR,
      ST_DONE
   } state_type;

endpackage

### sv/max_pool_2d.sv
// ----------------------------------------------------------------------------
// max_pool_2d
// Streaming 2-D max pooling, ceil mode, no padding, one channel plane at a
// time in raster order.
// ----------------------------------------------------------------------------
// Each pixel is folded into every window that covers it by a read-modify-write
// of a single-port window store, one window at a time. After the accept, the
// sequencer tests every window row (ST_ROW) and every window column position
// (ST_COL) that the pixel may fall in, the failing test that ends a scan
// included, writes every window it updates (ST_WR) and then hands its result
// to the output register (ST_DONE), held there while that register is full
// and stalled. The input stays stalled while a pixel is at work and while a
// configuration write is offered. A write of any register restarts the
// plane. The window store is not cleared: the first pixel of a window
// overwrites its entry.
module max_pool_2d
   import mp2d_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   parameter int MAX_KERNEL = DEF_MAX_KERNEL,
   parameter int DATA_BITS  = DEF_DATA_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [DATA_BITS-1:0]   req_pixel,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [DATA_BITS-1:0]   rsp_pooled_value,
   output logic [OUT_IDX_BITS-1:0]       rsp_out_row,
   output logic [OUT_IDX_BITS-1:0]       rsp_out_col,
   output logic                          rsp_plane_done,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_data
);

   localparam int RB   = $clog2(MAX_HEIGHT);
   localparam int CLB  = $clog2(MAX_WIDTH);
   localparam int HB   = $clog2(MAX_HEIGHT + 1);
   localparam int WB   = $clog2(MAX_WIDTH + 1);
   localparam int KB   = $clog2(MAX_KERNEL + 1);
   localparam int KL   = $clog2(MAX_KERNEL);
   localparam int DB   = (HB > WB) ? HB : WB;
   localparam int CB   = ((DB > CFG_DIM_BITS) ? DB : CFG_DIM_BITS) + 1;
   localparam int AB   = KL + CLB;
   localparam int DEPTH = 1 << AB;

   // configuration
   logic [CFG_DIM_BITS-1:0] in_height_ff, in_width_ff;
   logic [CFG_K_BITS-1:0]   kernel_h_ff, kernel_w_ff, stride_h_ff, stride_w_ff;

   // effective geometry
   logic [HB-1:0] h_eff;
   logic [WB-1:0] w_eff;
   logic [KB-1:0] kh_eff, kw_eff, sh_eff, sw_eff;
   logic [CB-1:0] kmax_h, kmax_w, lim_h, lim_w;

   // plane position
   logic [RB-1:0]  row_pos_ff, row_quo_ff;
   logic [KL-1:0]  row_rem_ff;
   logic [CLB-1:0] col_pos_ff, col_quo_ff;
   logic [KL-1:0]  col_rem_ff;

   // working copy of the pixel at hand
   logic signed [DATA_BITS-1:0] px_ff;
   logic [RB-1:0]  cur_row_ff;
   logic [CLB-1:0] cur_col_ff, cur_cq_ff, cur_cs_ff;
   logic [RB-1:0]  orow_ff, rs_ff;
   logic [CLB-1:0] ocol_ff, cs_ff;

   // pending result
   logic                        res_pend_ff;
   logic signed [DATA_BITS-1:0] res_val_ff;
   logic [RB-1:0]               res_row_ff;
   logic [CLB-1:0]              res_col_ff;
   logic                        res_done_ff;

   // window store
   logic signed [DATA_BITS-1:0] store_mem [DEPTH];
   logic signed [DATA_BITS-1:0] rd_ff;
   logic [AB-1:0]               mem_addr;
   logic                        mem_we;
   logic signed [DATA_BITS-1:0] wr_val;

   state_type state_ff, state_in;

   logic req_take, csr_take, out_load;
   logic row_in, row_ok, col_in, col_ok, win_first, win_end, win_last;

   // --------------------------------------------------------------------
   // effective values
   always_comb begin
      if (in_height_ff == '0) begin
         h_eff = HB'(1);
      end else if (CB'(in_height_ff) > CB'(MAX_HEIGHT)) begin
         h_eff = HB'(MAX_HEIGHT);
      end else begin
         h_eff = HB'(in_height_ff);
      end
      if (in_width_ff == '0) begin
         w_eff = WB'(1);
      end else if (CB'(in_width_ff) > CB'(MAX_WIDTH)) begin
         w_eff = WB'(MAX_WIDTH);
      end else begin
         w_eff = WB'(in_width_ff);
      end
      kmax_h = (CB'(MAX_KERNEL) < CB'(h_eff)) ? CB'(MAX_KERNEL) : CB'(h_eff);
      kmax_w = (CB'(MAX_KERNEL) < CB'(w_eff)) ? CB'(MAX_KERNEL) : CB'(w_eff);
      if (kernel_h_ff == '0) begin
         kh_eff = KB'(1);
      end else if (CB'(kernel_h_ff) > kmax_h) begin
         kh_eff = KB'(kmax_h);
      end else begin
         kh_eff = KB'(kernel_h_ff);
      end
      if (kernel_w_ff == '0) begin
         kw_eff = KB'(1);
      end else if (CB'(kernel_w_ff) > kmax_w) begin
         kw_eff = KB'(kmax_w);
      end else begin
         kw_eff = KB'(kernel_w_ff);
      end
      if (stride_h_ff == '0) begin
         sh_eff = KB'(1);
      end else if (CB'(stride_h_ff) > CB'(kh_eff)) begin
         sh_eff = kh_eff;
      end else begin
         sh_eff = KB'(stride_h_ff);
      end
      if (stride_w_ff == '0) begin
         sw_eff = KB'(1);
      end else if (CB'(stride_w_ff) > CB'(kw_eff)) begin
         sw_eff = kw_eff;
      end else begin
         sw_eff = KB'(stride_w_ff);
      end
      lim_h = CB'(h_eff) - CB'(kh_eff) + CB'(sh_eff);
      lim_w = CB'(w_eff) - CB'(kw_eff) + CB'(sw_eff);
   end

   // window tests
   always_comb begin
      row_in    = (CB'(cur_row_ff) - CB'(rs_ff)) < CB'(kh_eff);
      row_ok    = CB'(rs_ff) < lim_h;
      col_in    = (CB'(cur_col_ff) - CB'(cs_ff)) < CB'(kw_eff);
      col_ok    = CB'(cs_ff) < lim_w;
      win_first = (cur_row_ff == rs_ff) && (cur_col_ff == cs_ff);
      win_end   = ((CB'(cur_row_ff) == CB'(rs_ff) + CB'(kh_eff) - CB'(1)) ||
                   (CB'(cur_row_ff) == CB'(h_eff) - CB'(1))) &&
                  ((CB'(cur_col_ff) == CB'(cs_ff) + CB'(kw_eff) - CB'(1)) ||
                   (CB'(cur_col_ff) == CB'(w_eff) - CB'(1)));
      win_last  = (CB'(rs_ff) + CB'(kh_eff) >= CB'(h_eff)) &&
                  (CB'(cs_ff) + CB'(kw_eff) >= CB'(w_eff));
      if (win_first || (px_ff > rd_ff)) begin
         wr_val = px_ff;
      end else begin
         wr_val = rd_ff;
      end
   end

   assign mem_addr = {orow_ff[KL-1:0], ocol_ff};

   // --------------------------------------------------------------------
   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_ROW;
            end
         end
         ST_ROW: begin
            if (!row_in) begin
               state_in = ST_DONE;
            end else if (row_ok) begin
               state_in = ST_COL;
            end
         end
         ST_COL: begin
            if (!col_in) begin
               state_in = (orow_ff == '0) ? ST_DONE : ST_ROW;
            end else if (col_ok) begin
               state_in = ST_WR;
            end
         end
         ST_WR: begin
            if (ocol_ff == '0) begin
               state_in = (orow_ff == '0) ? ST_DONE : ST_ROW;
            end else begin
               state_in = ST_COL;
            end
         end
         ST_DONE: begin
            if (!res_pend_ff || !rsp_valid || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      csr_ready = (state_ff == ST_IDLE);
      req_stall = (state_ff != ST_IDLE) || csr_valid;
      mem_we    = (state_ff == ST_WR);
      out_load  = (state_ff == ST_DONE) && res_pend_ff && (!rsp_valid || !rsp_stall);
      req_take  = req_valid && !req_stall;
      csr_take  = csr_valid && csr_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // --------------------------------------------------------------------
   // configuration and plane position
   always_ff @(posedge clock) begin
      if (reset) begin
         in_height_ff <= RST_IN_HEIGHT;
         in_width_ff  <= RST_IN_WIDTH;
         kernel_h_ff  <= RST_KERNEL;
         kernel_w_ff  <= RST_KERNEL;
         stride_h_ff  <= RST_STRIDE;
         stride_w_ff  <= RST_STRIDE;
         row_pos_ff   <= '0;
         row_quo_ff   <= '0;
         row_rem_ff   <= '0;
         col_pos_ff   <= '0;
         col_quo_ff   <= '0;
         col_rem_ff   <= '0;
      end else if (csr_take) begin
         case (csr_index)
            CSR_IN_HEIGHT: in_height_ff <= CFG_DIM_BITS'(csr_data);
            CSR_IN_WIDTH:  in_width_ff  <= CFG_DIM_BITS'(csr_data);
            CSR_KERNEL_H:  kernel_h_ff  <= CFG_K_BITS'(csr_data);
            CSR_KERNEL_W:  kernel_w_ff  <= CFG_K_BITS'(csr_data);
            CSR_STRIDE_H:  stride_h_ff  <= CFG_K_BITS'(csr_data);
            CSR_STRIDE_W:  stride_w_ff  <= CFG_K_BITS'(csr_data);
            default: ;
         endcase
         case (csr_index)
            CSR_IN_HEIGHT, CSR_IN_WIDTH, CSR_KERNEL_H,
            CSR_KERNEL_W, CSR_STRIDE_H, CSR_STRIDE_W: begin
               row_pos_ff <= '0;
               row_quo_ff <= '0;
               row_rem_ff <= '0;
               col_pos_ff <= '0;
               col_quo_ff <= '0;
               col_rem_ff <= '0;
            end
            default: ;
         endcase
      end else if (req_take) begin
         if (CB'(col_pos_ff) + CB'(1) >= CB'(w_eff)) begin
            col_pos_ff <= '0;
            col_quo_ff <= '0;
            col_rem_ff <= '0;
            if (CB'(row_pos_ff) + CB'(1) >= CB'(h_eff)) begin
               row_pos_ff <= '0;
               row_quo_ff <= '0;
               row_rem_ff <= '0;
            end else begin
               row_pos_ff <= row_pos_ff + RB'(1);
               if (KB'(row_rem_ff) + KB'(1) == sh_eff) begin
                  row_rem_ff <= '0;
                  row_quo_ff <= row_quo_ff + RB'(1);
               end else begin
                  row_rem_ff <= row_rem_ff + KL'(1);
               end
            end
         end else begin
            col_pos_ff <= col_pos_ff + CLB'(1);
            if (KB'(col_rem_ff) + KB'(1) == sw_eff) begin
               col_rem_ff <= '0;
               col_quo_ff <= col_quo_ff + CLB'(1);
            end else begin
               col_rem_ff <= col_rem_ff + KL'(1);
            end
         end
      end
   end

   // --------------------------------------------------------------------
   // window walk
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               px_ff      <= req_pixel;
               cur_row_ff <= row_pos_ff;
               cur_col_ff <= col_pos_ff;
               cur_cq_ff  <= col_quo_ff;
               cur_cs_ff  <= col_pos_ff - CLB'(col_rem_ff);
               orow_ff    <= row_quo_ff;
               rs_ff      <= row_pos_ff - RB'(row_rem_ff);
            end
         end
         ST_ROW: begin
            if (row_in && !row_ok) begin
               orow_ff <= orow_ff - RB'(1);
               rs_ff   <= rs_ff - RB'(sh_eff);
            end else if (row_in) begin
               ocol_ff <= cur_cq_ff;
               cs_ff   <= cur_cs_ff;
            end
         end
         ST_COL: begin
            if (!col_in) begin
               if (orow_ff != '0) begin
                  orow_ff <= orow_ff - RB'(1);
                  rs_ff   <= rs_ff - RB'(sh_eff);
               end
            end else if (!col_ok) begin
               ocol_ff <= ocol_ff - CLB'(1);
               cs_ff   <= cs_ff - CLB'(sw_eff);
            end
         end
         ST_WR: begin
            if (ocol_ff == '0) begin
               if (orow_ff != '0) begin
                  orow_ff <= orow_ff - RB'(1);
                  rs_ff   <= rs_ff - RB'(sh_eff);
               end
            end else begin
               ocol_ff <= ocol_ff - CLB'(1);
               cs_ff   <= cs_ff - CLB'(sw_eff);
            end
         end
         default: ;
      endcase
   end

   // capture the completed window
   always_ff @(posedge clock) begin
      if (reset) begin
         res_pend_ff <= 1'b0;
      end else if (req_take) begin
         res_pend_ff <= 1'b0;
      end else if (mem_we && win_end && !res_pend_ff) begin
         res_pend_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we && win_end && !res_pend_ff) begin
         res_val_ff  <= wr_val;
         res_row_ff  <= orow_ff;
         res_col_ff  <= ocol_ff;
         res_done_ff <= win_last;
      end
   end

   // window store, single port, read-first
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_addr] <= wr_val;
      end
      rd_ff <= store_mem[mem_addr];
   end

   // --------------------------------------------------------------------
   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (out_load) begin
         rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_pooled_value <= res_val_ff;
         rsp_out_row      <= OUT_IDX_BITS'(res_row_ff);
         rsp_out_col      <= OUT_IDX_BITS'(res_col_ff);
         rsp_plane_done   <= res_done_ff;
      end
   end

endmodule

### sv/mp2d_checker.sv
// ----------------------------------------------------------------------------
// mp2d_checker
// Port-level checks of the 2-D max pooling block, bound to its top level.
// ----------------------------------------------------------------------------
module mp2d_checker
   import mp2d_pkg::*;
#(
   parameter int DATA_BITS = DEF_DATA_BITS
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic signed [DATA_BITS-1:0] rsp_pooled_value,
   input logic [OUT_IDX_BITS-1:0]     rsp_out_row,
   input logic [OUT_IDX_BITS-1:0]     rsp_out_col,
   input logic                        rsp_plane_done,
   input logic                        csr_valid,
   input logic                        csr_ready
);

   // drop any result after reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   // hold the input off while a pixel is at work
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input word taken on the cycle after a take");

   // never take a pixel and a register write together
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(csr_valid && csr_ready && req_valid && !req_stall))
      else $error("register write and input word on the same edge");

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_pooled_value) &&
         $stable(rsp_out_row) && $stable(rsp_out_col) && $stable(rsp_plane_done)))
      else $error("stalled result word changed");

endmodule

bind max_pool_2d mp2d_checker #(.DATA_BITS(DATA_BITS)) u_mp2d_checker (.*);

### verif/max_pool_2d_test.sv
// ----------------------------------------------------------------------------
// max_pool_2d_test
// Self-checking bench for the streaming 2-D max pooling block. A short stimulus
// table (fixed extremes, a mid-plane restart, a stride clamp) is followed by
// random geometry phases: small planes, clamped register values, one full-width
// plane, and one phase that holds the result side off long enough to back up
// the input. Every accepted pixel is folded into a local window-max model whose
// pooled words are compared field by field with the block's output words.
// ----------------------------------------------------------------------------
module max_pool_2d_test;
   import mp2d_pkg::*;

   localparam int DRAIN_CYCLES = 200;
   localparam int HOLD_CYCLES  = 400;
   localparam int RANDOM_ITEMS = 1730;
   localparam int PRINT_LIMIT  = 40;

   typedef struct packed {
      logic signed [15:0] value;
      logic [9:0]         row;
      logic [9:0]         col;
      logic               done;
   } pooled_type;

   typedef enum logic [1:0] {ROW_CSR, ROW_PIX, ROW_PIX_KNOWN} row_kind_type;

   typedef struct packed {
      row_kind_type       kind;
      csr_index_type      index;
      logic [10:0]        data;
      logic signed [15:0] pixel;
      pooled_type         want;
   } script_row_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic signed [15:0]   req_pixel;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic signed [15:0]   rsp_pooled_value;
   logic [9:0]           rsp_out_row;
   logic [9:0]           rsp_out_col;
   logic                 rsp_plane_done;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [2:0]           csr_index;
   logic [10:0]          csr_data;

   int unsigned cfg_in_height, cfg_in_width;
   int unsigned cfg_kernel_h, cfg_kernel_w, cfg_stride_h, cfg_stride_w;
   int unsigned next_row, next_col;
   logic signed [15:0] peak_store [DEF_MAX_KERNEL*DEF_MAX_WIDTH];

   pooled_type pooled_due [$];
   int      mismatches  = 0;
   int      words_seen  = 0;
   int      pixels_sent = 0;
   int      phases_run  = 0;
   int      holds_done  = 0;
   int      send_mode   = 1;
   int      rsp_mode    = 1;
   bit      hold_rsp    = 0;

   max_pool_2d i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel        (req_pixel),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pooled_value (rsp_pooled_value),
      .rsp_out_row      (rsp_out_row),
      .rsp_out_col      (rsp_out_col),
      .rsp_plane_done   (rsp_plane_done),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("max_pool_2d_test: FAIL");
      $finish;
   end

   function automatic int unsigned min_u(int unsigned a, int unsigned b);
      return (a < b) ? a : b;
   endfunction

   function automatic int unsigned clamp_u(int unsigned v, int unsigned lo, int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int draw_gap(int mode);
      case (mode)
         0: return 0;
         1: return $urandom_range(0, 15);
         default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 15) : 0;
      endcase
   endfunction

   function automatic logic signed [15:0] draw_pixel();
      case ($urandom_range(0, 9))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'($signed($urandom_range(0, 8)) - 4);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic bit pool_pixel(input logic signed [15:0] px, output pooled_type res);
      int unsigned h, w, kh, kw, sh, sw, oh, ow, r, c, rs, cs, idx;
      int orw, ocl;
      logic signed [15:0] m;
      bit hit;
      hit = 0;
      res = '0;
      h  = clamp_u(cfg_in_height, 1, DEF_MAX_HEIGHT);
      w  = clamp_u(cfg_in_width, 1, DEF_MAX_WIDTH);
      kh = clamp_u(cfg_kernel_h, 1, min_u(DEF_MAX_KERNEL, h));
      kw = clamp_u(cfg_kernel_w, 1, min_u(DEF_MAX_KERNEL, w));
      sh = clamp_u(cfg_stride_h, 1, kh);
      sw = clamp_u(cfg_stride_w, 1, kw);
      oh = (h - kh + sh - 1) / sh + 1;
      ow = (w - kw + sw - 1) / sw + 1;
      if (next_row >= h || next_col >= w) begin
         next_row = 0;
         next_col = 0;
      end
      r = next_row;
      c = next_col;
      for (orw = int'(min_u(r / sh, oh - 1)); orw >= 0 && r < orw * sh + kh; orw--) begin
         rs = orw * sh;
         for (ocl = int'(min_u(c / sw, ow - 1)); ocl >= 0 && c < ocl * sw + kw; ocl--) begin
            cs  = ocl * sw;
            idx = (orw % DEF_MAX_KERNEL) * DEF_MAX_WIDTH + ocl;
            if (r == rs && c == cs) begin
               m = px;
            end else begin
               m = (px > peak_store[idx]) ? px : peak_store[idx];
            end
            peak_store[idx] = m;
            if (!hit && r == min_u(rs + kh, h) - 1 && c == min_u(cs + kw, w) - 1) begin
               res.value = m;
               res.row   = orw[9:0];
               res.col   = ocl[9:0];
               res.done  = (orw == oh - 1 && ocl == ow - 1);
               hit = 1;
            end
         end
      end
      next_col = c + 1;
      if (next_col >= w) begin
         next_col = 0;
         next_row = (r + 1 >= h) ? 0 : r + 1;
      end
      return hit;
   endfunction

   task automatic flag_mismatch(string what, int got, int want);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
         $display("mismatch at word %0d: %s got %0d expected %0d", words_seen, what, got, want);
   endtask

   task automatic check_word();
      pooled_type want;
      words_seen++;
      if (pooled_due.size() == 0) begin
         flag_mismatch("word with none due, row", rsp_out_row, -1);
         return;
      end
      want = pooled_due.pop_front();
      if (rsp_pooled_value !== want.value)
         flag_mismatch("pooled_value", int'(rsp_pooled_value), int'($signed(want.value)));
      if (rsp_out_row !== want.row)
         flag_mismatch("out_row", rsp_out_row, want.row);
      if (rsp_out_col !== want.col)
         flag_mismatch("out_col", rsp_out_col, want.col);
      if (rsp_plane_done !== want.done)
         flag_mismatch("plane_done", rsp_plane_done, want.done);
   endtask

   task automatic send_pixel(input logic signed [15:0] px, input bit known, input pooled_type want);
      pooled_type res;
      bit hit;
      int g;
      @(negedge clock);
      req_valid <= 1'b1;
      req_pixel <= px;
      do @(posedge clock); while (req_stall !== 1'b0);
      hit = pool_pixel(px, res);
      if (known) pooled_due.push_back(want);
      else if (hit) pooled_due.push_back(res);
      pixels_sent++;
      g = draw_gap(send_mode);
      if (g > 0) begin
         @(negedge clock) req_valid <= 1'b0;
         repeat (g - 1) @(negedge clock);
      end
   endtask

   task automatic wait_for_pooled();
      @(negedge clock) req_valid <= 1'b0;
      while (pooled_due.size() != 0) @(posedge clock);
   endtask

   task automatic settle_block();
      wait_for_pooled();
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [10:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         CSR_IN_HEIGHT: cfg_in_height = data;
         CSR_IN_WIDTH:  cfg_in_width  = data;
         CSR_KERNEL_H:  cfg_kernel_h  = data[3:0];
         CSR_KERNEL_W:  cfg_kernel_w  = data[3:0];
         CSR_STRIDE_H:  cfg_stride_h  = data[3:0];
         CSR_STRIDE_W:  cfg_stride_w  = data[3:0];
         default: ;
      endcase
      next_row = 0;
      next_col = 0;
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   task automatic apply_geometry(int h, int w, int kh, int kw, int sh, int sw);
      settle_block();
      csr_write(CSR_IN_HEIGHT, 11'(h));
      csr_write(CSR_IN_WIDTH,  11'(w));
      csr_write(CSR_KERNEL_H,  11'(kh));
      csr_write(CSR_KERNEL_W,  11'(kw));
      csr_write(CSR_STRIDE_H,  11'(sh));
      csr_write(CSR_STRIDE_W,  11'(sw));
      phases_run++;
   endtask

   initial begin : result_side
      int w;
      rsp_stall = 1'b0;
      @(posedge clock);
      wait (reset === 1'b0);
      forever begin
         w = draw_gap(rsp_mode);
         if (hold_rsp) begin
            w = HOLD_CYCLES;
            hold_rsp = 0;
            holds_done++;
         end
         if (w > 0) begin
            @(negedge clock) rsp_stall <= 1'b1;
            repeat (w) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (rsp_valid !== 1'b1);
         check_word();
      end
   end

   initial begin : stimulus
      script_row_type script [$];
      pooled_type none;
      int random_sent, n, h, w, kh, kw, sh, sw;
      none = '0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_pixel = '0;
      csr_valid = 1'b0;
      csr_index = CSR_IN_HEIGHT;
      csr_data  = '0;
      cfg_in_height = RST_IN_HEIGHT;
      cfg_in_width  = RST_IN_WIDTH;
      cfg_kernel_h  = RST_KERNEL;
      cfg_kernel_w  = RST_KERNEL;
      cfg_stride_h  = RST_STRIDE;
      cfg_stride_w  = RST_STRIDE;
      next_row = 0;
      next_col = 0;
      script = '{
         '{ROW_CSR,       CSR_IN_HEIGHT, 11'd2, 16'sh0000, none},
         '{ROW_CSR,       CSR_IN_WIDTH,  11'd4, 16'sh0000, none},
         '{ROW_PIX,       CSR_IN_HEIGHT, 11'd0, 16'sh8000, none},
         '{ROW_PIX,       CSR_IN_HEIGHT, 11'd0, 16'sh8000, none},
         '{ROW_PIX,       CSR_IN_HEIGHT, 11'd0, 16'sh7FFF, none},
         '{ROW_PIX,       CSR_IN_HEIGHT, 11'd0, 16'sh8000, none},
         '{ROW_PIX,       CSR_IN_HEIGHT, 11'd0, 16'sh8000, none},
         '{ROW_PIX_KNOWN, CSR_IN_HEIGHT, 11'd0, 16'sh8000,
           '{16'sh8000, 10'd0, 10'd0, 1'b0}},
         '{ROW_PIX,       CSR_IN_HEIGHT, 11'd0, 16'sh0000, none},
         '{ROW_PIX_KNOWN, CSR_IN_HEIGHT, 11'd0, 16'shFFFF,
           '{16'sh7FFF, 10'd0, 10'd1, 1'b1}},
         '{ROW_PIX,       CSR_IN_HEIGHT, 11'd0, 16'sh5555, none},
         '{ROW_PIX,       CSR_IN_HEIGHT, 11'd0, 16'shAAAA, none},
         '{ROW_PIX,       CSR_IN_HEIGHT, 11'd0, 16'sh1234, none},
         '{ROW_CSR,       CSR_STRIDE_W,  11'd0, 16'sh0000, none},
         '{ROW_PIX,       CSR_IN_HEIGHT, 11'd0, 16'sh0100, none},
         '{ROW_PIX,       CSR_IN_HEIGHT, 11'd0, 16'shFFFF, none},
         '{ROW_PIX,       CSR_IN_HEIGHT, 11'd0, 16'sh8001, none},
         '{ROW_PIX,       CSR_IN_HEIGHT, 11'd0, 16'sh00FF, none},
         '{ROW_PIX,       CSR_IN_HEIGHT, 11'd0, 16'sh7FFE, none},
         '{ROW_PIX,       CSR_IN_HEIGHT, 11'd0, 16'sh0001, none},
         '{ROW_PIX,       CSR_IN_HEIGHT, 11'd0, 16'shFFFE, none},
         '{ROW_PIX,       CSR_IN_HEIGHT, 11'd0, 16'sh4000, none}
      };
      repeat (11) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].kind == ROW_CSR) begin
            settle_block();
            csr_write(script[i].index, script[i].data);
         end else begin
            send_pixel(script[i].pixel, script[i].kind == ROW_PIX_KNOWN, script[i].want);
         end
      end

      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         if (phases_run == 0) begin
            // back up the input behind a long result hold, then drain mid-phase
            apply_geometry(6, 9, 1, 1, 1, 1);
            send_mode = 0;
            rsp_mode  = 1;
            hold_rsp  = 1;
            n = 120;
         end else if (phases_run == 1) begin
            apply_geometry(1, 2047, 0, 0, 15, 15);
            send_mode = 2;
            rsp_mode  = 2;
            n = 1030;
         end else begin
            h  = $urandom_range(1, 10);
            w  = $urandom_range(1, 12);
            kh = $urandom_range(1, 8);
            kw = $urandom_range(1, 8);
            sh = $urandom_range(1, kh);
            sw = $urandom_range(1, kw);
            case ($urandom_range(0, 9))
               0: h = $urandom_range(0, 1) ? 2047 : 0;
               1: w = 0;
               2: begin
                  kh = $urandom_range(0, 1) ? 15 : 0;
                  kw = 15;
               end
               3: begin
                  sh = $urandom_range(0, 1) ? 15 : 0;
                  sw = 15 - sh;
               end
               default: ;
            endcase
            apply_geometry(h, w, kh, kw, sh, sw);
            send_mode = $urandom_range(0, 2);
            rsp_mode  = $urandom_range(0, 2);
            n = $urandom_range(20, 90);
         end
         for (int k = 0; k < n; k++) begin
            if (phases_run == 1 && k == n / 2) wait_for_pooled();
            send_pixel(draw_pixel(), 1'b0, none);
            random_sent++;
         end
      end

      settle_block();
      $display("max_pool_2d_test: %0d pixels over %0d register phases, %0d pooled words checked",
               pixels_sent, phases_run, words_seen);
      $display("max_pool_2d_test: %0d long result holds, clamped and full-width geometries,",
               holds_done);
      $display("max_pool_2d_test: %0d mismatches", mismatches);
      if (mismatches == 0) begin
         $display("max_pool_2d_test: PASS");
      end else begin
         $display("max_pool_2d_test: FAIL");
      end
      $finish;
   end

endmodule
